// File: rtl/core/rsm_pkg.sv
// Package with the shared types, constants and exponent table of the row softmax core.
`timescale 1ns / 1ps
package rsm_pkg;

    localparam int ROW_MAX_DEF = 64;
    localparam int VAL_W       = 16;
    localparam int EXP_W       = 17;
    localparam int SUM_W       = 23;
    localparam int PROB_W      = 16;
    localparam int T_W         = 17;
    localparam int DIV_STEPS   = 17;
    localparam int DCNT_W      = 5;
    localparam logic [16:0] LOG2E_Q16 = 17'd94548;
    localparam logic [8:0]  SHIFT_LIMIT = 9'd17;

    typedef struct packed {
        logic load;
        logic e_rd;
        logic e_t;
        logic e_wr;
        logic d_rd;
        logic d_init;
        logic d_step;
        logic out_load;
        logic idx_inc;
        logic idx_clr;
        logic row_clr;
    } rsm_cmd_t;

    typedef struct packed {
        logic idx_last;
        logic div_done;
    } rsm_stat_t;

    // 2^(-i/16) in Q1.16 for i = 0..16.
    function automatic logic [EXP_W-1:0] pow2_tab(input logic [4:0] i);
        logic [EXP_W-1:0] r;
        case (i)
            5'd0:    r = 17'd65536;
            5'd1:    r = 17'd62757;
            5'd2:    r = 17'd60097;
            5'd3:    r = 17'd57549;
            5'd4:    r = 17'd55109;
            5'd5:    r = 17'd52773;
            5'd6:    r = 17'd50535;
            5'd7:    r = 17'd48393;
            5'd8:    r = 17'd46341;
            5'd9:    r = 17'd44376;
            5'd10:   r = 17'd42495;
            5'd11:   r = 17'd40693;
            5'd12:   r = 17'd38968;
            5'd13:   r = 17'd37316;
            5'd14:   r = 17'd35734;
            5'd15:   r = 17'd34219;
            default: r = 17'd32768;
        endcase
        return r;
    endfunction

endpackage

// File: rtl/core/rsm_in_if.sv
// Element channel interface: one row element per beat.
`timescale 1ns / 1ps
interface rsm_in_if;
    logic                               valid;
    logic                               ready;
    logic signed [rsm_pkg::VAL_W-1:0]   value;
    logic                               last;

    modport source (output valid, output value, output last, input ready);
    modport sink   (input valid, input value, input last, output ready);
endinterface

// File: rtl/core/rsm_out_if.sv
// Result channel interface: one probability per beat.
`timescale 1ns / 1ps
interface rsm_out_if;
    logic                           valid;
    logic                           ready;
    logic [rsm_pkg::PROB_W-1:0]     prob;
    logic                           last_res;
    logic                           overflow;

    modport source (output valid, output prob, output last_res, output overflow, input ready);
    modport sink   (input valid, input prob, input last_res, input overflow, output ready);
endinterface

// File: rtl/core/rsm_ctrl.sv
// Sequencer for loading, exponent pass, division pass and result delivery.
`timescale 1ns / 1ps
module rsm_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_last,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    input  rsm_pkg::rsm_stat_t stat,
    output rsm_pkg::rsm_cmd_t  cmd
);

    typedef enum logic [3:0] {
        S_LOAD, S_E_RD, S_E_T, S_E_M, S_D_RD, S_D_INIT, S_D_STEP, S_D_FIN, S_OUT
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_LOAD:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (in_last)
                    begin
                        cmd.idx_clr = 1'b1;
                        state_next  = S_E_RD;
                    end
                end
            end
            S_E_RD:
            begin
                cmd.e_rd   = 1'b1;
                state_next = S_E_T;
            end
            S_E_T:
            begin
                cmd.e_t    = 1'b1;
                state_next = S_E_M;
            end
            S_E_M:
            begin
                cmd.e_wr = 1'b1;
                if (stat.idx_last)
                begin
                    cmd.idx_clr = 1'b1;
                    state_next  = S_D_RD;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = S_E_RD;
                end
            end
            S_D_RD:
            begin
                cmd.d_rd   = 1'b1;
                state_next = S_D_INIT;
            end
            S_D_INIT:
            begin
                cmd.d_init = 1'b1;
                state_next = S_D_STEP;
            end
            S_D_STEP:
            begin
                cmd.d_step = 1'b1;
                if (stat.div_done)
                    state_next = S_D_FIN;
            end
            S_D_FIN:
            begin
                cmd.out_load = 1'b1;
                state_next   = S_OUT;
            end
            S_OUT:
            begin
                if (out_ready)
                begin
                    if (stat.idx_last)
                    begin
                        cmd.row_clr = 1'b1;
                        state_next  = S_LOAD;
                    end
                    else
                    begin
                        cmd.idx_inc = 1'b1;
                        state_next  = S_D_RD;
                    end
                end
            end
            default: state_next = S_LOAD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_LOAD;
        else
            state_reg <= state_next;
    end

    assign in_ready  = (state_reg == S_LOAD);
    assign out_valid = (state_reg == S_OUT);

endmodule

// File: rtl/core/rsm_dp.sv
// Datapath: row and exponent stores, maximum, exponent unit, sum and serial divider.
`timescale 1ns / 1ps
module rsm_dp #(
    parameter int ROW_MAX = rsm_pkg::ROW_MAX_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  rsm_pkg::rsm_cmd_t                 cmd,
    output rsm_pkg::rsm_stat_t                stat,
    input  logic signed [rsm_pkg::VAL_W-1:0]  in_value,
    output logic [rsm_pkg::PROB_W-1:0]        prob,
    output logic                              last_res,
    output logic                              overflow
);

    localparam int CW = $clog2(ROW_MAX + 1);
    localparam int IW = $clog2(ROW_MAX);

    logic signed [rsm_pkg::VAL_W-1:0] row_mem [ROW_MAX];
    logic [rsm_pkg::EXP_W-1:0]        exp_mem [ROW_MAX];

    logic [CW-1:0]                    count_reg;
    logic signed [rsm_pkg::VAL_W-1:0] max_reg;
    logic                             ovf_reg;
    logic [rsm_pkg::SUM_W-1:0]        sum_reg;
    logic [IW-1:0]                    idx_reg;
    logic signed [rsm_pkg::VAL_W-1:0] row_rd_reg;
    logic [rsm_pkg::EXP_W-1:0]        exp_rd_reg;
    logic [rsm_pkg::T_W-1:0]          t_reg;
    logic [rsm_pkg::SUM_W-1:0]        rem_reg;
    logic [rsm_pkg::EXP_W-1:0]        q_reg;
    logic [rsm_pkg::DCNT_W-1:0]       dcnt_reg;
    logic [rsm_pkg::PROB_W-1:0]       prob_reg;
    logic                             last_res_reg;
    logic                             ovf_out_reg;

    logic                             room;
    logic [15:0]                      diff_d;
    logic [32:0]                      prod_t;
    logic [4:0]                       k5;
    logic [rsm_pkg::EXP_W-1:0]        tk, tk1, tdiff;
    logic [20:0]                      corr;
    logic [rsm_pkg::EXP_W-1:0]        mant, e_val;
    logic [33:0]                      num;
    logic [rsm_pkg::SUM_W:0]          trial;
    logic                             fits;

    assign room = (count_reg < CW'(ROW_MAX));
    assign stat.idx_last = (idx_reg == IW'(count_reg - CW'(1)));
    assign stat.div_done = (dcnt_reg == rsm_pkg::DCNT_W'(rsm_pkg::DIV_STEPS - 1));

    // Exponent: t = d * log2(e) rounded to Q9.8, then table plus linear step and shift.
    always_comb
    begin
        diff_d = 16'(max_reg - row_rd_reg);
        prod_t = 33'(diff_d) * 33'(rsm_pkg::LOG2E_Q16) + 33'd32768;
        k5     = {1'b0, t_reg[7:4]};
        tk     = rsm_pkg::pow2_tab(k5);
        tk1    = rsm_pkg::pow2_tab(k5 + 5'd1);
        tdiff  = tk - tk1;
        corr   = (21'(tdiff) * 21'(t_reg[3:0]) + 21'd8) >> 4;
        mant   = tk - corr[rsm_pkg::EXP_W-1:0];
        if (t_reg[16:8] >= rsm_pkg::SHIFT_LIMIT)
            e_val = '0;
        else
            e_val = mant >> t_reg[12:8];
        num   = {1'b0, exp_rd_reg, 16'd0} + 34'(sum_reg[rsm_pkg::SUM_W-1:1]);
        trial = {rem_reg, q_reg[rsm_pkg::EXP_W-1]};
        fits  = (trial >= {1'b0, sum_reg});
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load && room)
            row_mem[count_reg[IW-1:0]] <= in_value;
        if (cmd.e_rd)
            row_rd_reg <= row_mem[idx_reg];
        if (cmd.e_wr)
            exp_mem[idx_reg] <= e_val;
        if (cmd.d_rd)
            exp_rd_reg <= exp_mem[idx_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.e_t)
            t_reg <= prod_t[32:16];
        if (cmd.d_init)
        begin
            rem_reg <= rsm_pkg::SUM_W'(num[33:17]);
            q_reg   <= num[16:0];
        end
        else if (cmd.d_step)
        begin
            if (fits)
            begin
                rem_reg <= rsm_pkg::SUM_W'(trial - {1'b0, sum_reg});
                q_reg   <= {q_reg[rsm_pkg::EXP_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial[rsm_pkg::SUM_W-1:0];
                q_reg   <= {q_reg[rsm_pkg::EXP_W-2:0], 1'b0};
            end
        end
        if (cmd.out_load)
        begin
            // A zero sum cannot arise, but it yields zero rather than garbage.
            if (sum_reg == '0)
                prob_reg <= '0;
            else if (q_reg[rsm_pkg::EXP_W-1])
                prob_reg <= '1;
            else
                prob_reg <= q_reg[rsm_pkg::PROB_W-1:0];
            last_res_reg <= stat.idx_last;
            ovf_out_reg  <= ovf_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            max_reg   <= 16'sh8000;
            ovf_reg   <= 1'b0;
            sum_reg   <= '0;
            idx_reg   <= '0;
            dcnt_reg  <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                if (room)
                begin
                    count_reg <= count_reg + CW'(1);
                    if (in_value > max_reg)
                        max_reg <= in_value;
                end
                else
                    ovf_reg <= 1'b1;
                sum_reg <= '0;
            end
            if (cmd.e_wr)
                sum_reg <= sum_reg + rsm_pkg::SUM_W'(e_val);
            if (cmd.idx_clr)
                idx_reg <= '0;
            else if (cmd.idx_inc)
                idx_reg <= idx_reg + IW'(1);
            if (cmd.d_init)
                dcnt_reg <= '0;
            else if (cmd.d_step)
                dcnt_reg <= dcnt_reg + rsm_pkg::DCNT_W'(1);
            if (cmd.row_clr)
            begin
                count_reg <= '0;
                max_reg   <= 16'sh8000;
                ovf_reg   <= 1'b0;
                sum_reg   <= '0;
                idx_reg   <= '0;
            end
        end
    end

    assign prob     = prob_reg;
    assign last_res = last_res_reg;
    assign overflow = ovf_out_reg;

endmodule

// File: rtl/core/row_softmax_core.sv
// Top level of the row softmax core: controller and datapath.
`timescale 1ns / 1ps
// Row softmax over signed Q8.8 elements, one element per beat, with last on the
// final element. While loading, the row is stored and its maximum tracked. After
// the last element the exponent pass runs through the row store (read, exponent
// argument, exponent write per element), then each result is produced by an
// exponent store read, divider init, a 17-step serial divider and output load,
// followed by the wait for the sink. Elements beyond ROW_MAX are dropped and
// every result of that row carries overflow. No element is taken while a row
// is being emitted.
module row_softmax_core #(
    parameter int ROW_MAX = rsm_pkg::ROW_MAX_DEF
) (
    input  logic    clk,
    input  logic    rst_n,
    rsm_in_if.sink  elem,
    rsm_out_if.source result
);

    rsm_pkg::rsm_cmd_t  cmd;
    rsm_pkg::rsm_stat_t stat;

    rsm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (elem.valid),
        .in_last   (elem.last),
        .in_ready  (elem.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    rsm_dp #(.ROW_MAX(ROW_MAX)) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .stat     (stat),
        .in_value (elem.value),
        .prob     (result.prob),
        .last_res (result.last_res),
        .overflow (result.overflow)
    );

`ifndef ASSERT_OFF
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(result.valid && elem.ready))
        else $error("element accepted while a result is pending");

    a_row_end_load: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.ready && result.last_res) |=> elem.ready)
        else $error("core not ready for a new row after the final result");

    a_last_starts_pass: assert property (@(posedge clk) disable iff (!rst_n)
        (elem.valid && elem.ready && elem.last) |=> !elem.ready)
        else $error("core kept loading after the last element");
`endif

endmodule
